FILE: sv/sorted_id_set_engine_core_assert.svh
`ifndef SORTED_ID_SET_ENGINE_CORE_ASSERT_SVH
`define SORTED_ID_SET_ENGINE_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SISE_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication
`define SISE_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

FILE: sv/sise_pkg.sv
package sise_pkg;

  localparam int unsigned DepthDefault = 1024;
  localparam int unsigned IdW          = 32;
  localparam int unsigned CmdW         = 3;
  localparam int unsigned IdxW         = 10;
  localparam int unsigned CntW         = 11;
  localparam int unsigned StatusW      = 2;
  localparam int unsigned InDataW      = 48;
  localparam int unsigned OutDataW     = 56;

  typedef enum logic [CmdW-1:0] {
    CMD_CLEAR    = 3'd0,
    CMD_APP_OCC  = 3'd1,
    CMD_USE_ALL  = 3'd2,
    CMD_USE_NONE = 3'd3,
    CMD_INSERT   = 3'd4,
    CMD_REMOVE   = 3'd5,
    CMD_APP_USE  = 3'd6,
    CMD_READ     = 3'd7
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_ABSENT = 2'd2,
    STAT_BADIDX = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_WALK,
    FSM_READ,
    FSM_FIN
  } state_e;

endpackage

FILE: sv/sorted_id_set_engine_core.sv
// One item at a time. Clear, append, use none, insert on a full list and an
// out-of-range read go from idle straight to the result state; a read passes
// a read state first. Use all walks the occurrence list, insert and remove
// the usage list (up to DEPTH entries), the single read port walking one
// memory entry per cycle. Next item accepted once the result is
// registered. Reset clears lengths and control; memories are not cleared.
`include "sorted_id_set_engine_core_assert.svh"

module sorted_id_set_engine_core #(
  parameter int unsigned DEPTH = sise_pkg::DepthDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [31:0] id, [41:32] index, rest zero
  input  logic [sise_pkg::InDataW-1:0]   s_axis_tdata_i,
  // [2:0] command
  input  logic [sise_pkg::CmdW-1:0]      s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [10:0] usage_count, [21:11] occurrence_count, [53:22] read_value, rest zero
  output logic [sise_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // [1:0] status
  output logic [sise_pkg::StatusW-1:0]   m_axis_tuser_o
);

  import sise_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > IdxW) ? CW : IdxW;

  state_e            state_q, state_d;
  cmd_e              cmd_q, cmd_d, in_cmd;
  logic [IdW-1:0]    id_q, id_d, carry_q, carry_d, rval_q, rval_d;
  status_e           status_q, status_d;
  logic [CW-1:0]     olen_q, olen_d, ulen_q, ulen_d, rk_q, rk_d, lim;
  logic [AW-1:0]     pk_q, pk_d, pkm1;
  logic              pv_q, pv_d, found_q, found_d;
  logic              out_valid_q, out_valid_d;
  status_e           out_status_q, out_status_d;
  logic [CntW-1:0]   out_ucnt_q, out_ucnt_d, out_ocnt_q, out_ocnt_d;
  logic [IdW-1:0]    out_rval_q, out_rval_d;

  logic              accept, out_free, walk_done, u_full, o_full, bad_idx;
  logic [IdW-1:0]    in_id, walk_data;
  logic [XW-1:0]     idx_x, ulen_x;

  logic              o_we, o_re, u_we, u_re;
  logic [AW-1:0]     o_waddr, o_raddr, u_waddr, u_raddr;
  logic [IdW-1:0]    o_wdata, u_wdata, o_rdata, u_rdata;

  sise_ram #(.Depth(DEPTH), .DataW(IdW)) u_occ_ram (
    .clk_i  (clk_i),
    .we_i   (o_we),
    .waddr_i(o_waddr),
    .wdata_i(o_wdata),
    .re_i   (o_re),
    .raddr_i(o_raddr),
    .rdata_o(o_rdata)
  );

  sise_ram #(.Depth(DEPTH), .DataW(IdW)) u_use_ram (
    .clk_i  (clk_i),
    .we_i   (u_we),
    .waddr_i(u_waddr),
    .wdata_i(u_wdata),
    .re_i   (u_re),
    .raddr_i(u_raddr),
    .rdata_o(u_rdata)
  );

  assign s_axis_tready_o = (state_q == FSM_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign in_cmd          = cmd_e'(s_axis_tuser_i);
  assign in_id           = s_axis_tdata_i[IdW-1:0];
  assign idx_x           = XW'(s_axis_tdata_i[IdW+IdxW-1:IdW]);
  assign ulen_x          = XW'(ulen_q);
  assign bad_idx         = (idx_x >= ulen_x);
  assign u_full          = (ulen_q == CW'(DEPTH));
  assign o_full          = (olen_q == CW'(DEPTH));
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign lim             = (cmd_q == CMD_USE_ALL) ? olen_q : ulen_q;
  assign walk_data       = (cmd_q == CMD_USE_ALL) ? o_rdata : u_rdata;
  assign walk_done       = !pv_q && (rk_q >= lim);
  assign pkm1            = pk_q - AW'(1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            CMD_USE_ALL, CMD_REMOVE: state_d = FSM_WALK;
            CMD_INSERT:              state_d = u_full ? FSM_FIN : FSM_WALK;
            CMD_READ:                state_d = bad_idx ? FSM_FIN : FSM_READ;
            default:                 state_d = FSM_FIN;
          endcase
        end
      end
      FSM_WALK: begin
        if (walk_done) begin
          state_d = FSM_FIN;
        end
      end
      FSM_READ: state_d = FSM_FIN;
      FSM_FIN: begin
        if (out_free) begin
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cmd_d        = cmd_q;
    id_d         = id_q;
    carry_d      = carry_q;
    rval_d       = rval_q;
    status_d     = status_q;
    olen_d       = olen_q;
    ulen_d       = ulen_q;
    rk_d         = rk_q;
    pk_d         = pk_q;
    pv_d         = pv_q;
    found_d      = found_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_status_d = out_status_q;
    out_ucnt_d   = out_ucnt_q;
    out_ocnt_d   = out_ocnt_q;
    out_rval_d   = out_rval_q;
    o_we         = 1'b0;
    o_waddr      = olen_q[AW-1:0];
    o_wdata      = in_id;
    o_re         = 1'b0;
    o_raddr      = rk_q[AW-1:0];
    u_we         = 1'b0;
    u_waddr      = ulen_q[AW-1:0];
    u_wdata      = in_id;
    u_re         = 1'b0;
    u_raddr      = rk_q[AW-1:0];

    unique case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          cmd_d    = in_cmd;
          id_d     = in_id;
          status_d = STAT_OK;
          rval_d   = '0;
          rk_d     = '0;
          pv_d     = 1'b0;
          found_d  = 1'b0;
          unique case (in_cmd)
            CMD_CLEAR: begin
              olen_d = '0;
              ulen_d = '0;
            end
            CMD_APP_OCC: begin
              if (o_full) begin
                status_d = STAT_FULL;
              end else begin
                o_we   = 1'b1;
                olen_d = olen_q + CW'(1);
              end
            end
            CMD_USE_ALL, CMD_REMOVE: ;
            CMD_USE_NONE: ulen_d = '0;
            CMD_INSERT: begin
              if (u_full) begin
                status_d = STAT_FULL;
              end
            end
            CMD_APP_USE: begin
              if (u_full) begin
                status_d = STAT_FULL;
              end else begin
                u_we   = 1'b1;
                ulen_d = ulen_q + CW'(1);
              end
            end
            CMD_READ: begin
              if (bad_idx) begin
                status_d = STAT_BADIDX;
              end else begin
                u_re    = 1'b1;
                u_raddr = AW'(idx_x);
              end
            end
          endcase
        end
      end

      FSM_WALK: begin
        if (rk_q < lim) begin
          o_re = (cmd_q == CMD_USE_ALL);
          u_re = (cmd_q != CMD_USE_ALL);
          rk_d = rk_q + CW'(1);
          pk_d = rk_q[AW-1:0];
          pv_d = 1'b1;
        end else begin
          pv_d = 1'b0;
        end
        if (pv_q) begin
          u_waddr = pk_q;
          u_wdata = walk_data;
          unique case (cmd_q)
            CMD_USE_ALL: u_we = 1'b1;
            CMD_INSERT: begin
              // ripple: each entry from the insert point moves up by one
              if (found_q) begin
                u_we    = 1'b1;
                u_wdata = carry_q;
                carry_d = walk_data;
              end else if (walk_data > id_q) begin
                u_we    = 1'b1;
                u_wdata = id_q;
                carry_d = walk_data;
                found_d = 1'b1;
              end
            end
            CMD_REMOVE: begin
              if (found_q) begin
                u_we    = 1'b1;
                u_waddr = pkm1;
              end else if (walk_data == id_q) begin
                found_d = 1'b1;
              end
            end
            default: ;
          endcase
        end
        if (walk_done) begin
          unique case (cmd_q)
            CMD_USE_ALL: ulen_d = olen_q;
            CMD_INSERT: begin
              u_we    = 1'b1;
              u_waddr = ulen_q[AW-1:0];
              u_wdata = found_q ? carry_q : id_q;
              ulen_d  = ulen_q + CW'(1);
            end
            CMD_REMOVE: begin
              if (found_q) begin
                ulen_d = ulen_q - CW'(1);
              end else begin
                status_d = STAT_ABSENT;
              end
            end
            default: ;
          endcase
        end
      end

      FSM_READ: rval_d = u_rdata;

      FSM_FIN: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_ucnt_d   = CntW'(ulen_q);
          out_ocnt_d   = CntW'(olen_q);
          out_rval_d   = rval_q;
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      cmd_q       <= CMD_CLEAR;
      olen_q      <= '0;
      ulen_q      <= '0;
      rk_q        <= '0;
      pk_q        <= '0;
      pv_q        <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      olen_q      <= olen_d;
      ulen_q      <= ulen_d;
      rk_q        <= rk_d;
      pk_q        <= pk_d;
      pv_q        <= pv_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q         <= id_d;
    carry_q      <= carry_d;
    rval_q       <= rval_d;
    status_q     <= status_d;
    out_status_q <= out_status_d;
    out_ucnt_q   <= out_ucnt_d;
    out_ocnt_q   <= out_ocnt_d;
    out_rval_q   <= out_rval_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {{(OutDataW - 2*CntW - IdW){1'b0}},
                            out_rval_q, out_ocnt_q, out_ucnt_q};

  `SISE_ASSERT_IMP(a_len_bound, 1'b1, (ulen_q <= CW'(DEPTH)) && (olen_q <= CW'(DEPTH)))
  `SISE_ASSERT_IMP(a_rw_apart, u_we && u_re, u_waddr != u_raddr)
  `SISE_ASSERT_IMP(a_pk_range, (state_q == FSM_WALK) && pv_q, CW'(pk_q) < lim)
  `SISE_ASSERT_NXT(a_leave_idle, accept, state_q != FSM_IDLE)
  `SISE_ASSERT_IMP(a_out_from_fin, $rose(out_valid_q), $past(state_q == FSM_FIN))

endmodule

FILE: sv/sise_ram.sv
module sise_ram #(
  parameter int unsigned Depth = 2,
  parameter int unsigned DataW = 32,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
